// ----- sv/ubcs_pkg.sv -----
`timescale 1ns / 1ps

package ubcs_pkg;

  // request command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_BYTE  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_SRCH_INIT,
    OP_SRCH,
    OP_BYTE,
    OP_PAIR_RD,
    OP_PAIR_WR,
    OP_RD_BAD,
    OP_RD_READ,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIN,
    OP_VOCAB_CLR,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       clr_last;
    logic       srch_hit;
    logic       srch_miss;
    logic       complete;
    logic       rd_bad;
    logic       div_last;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_RST_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_SRCH_INIT,
    S_SRCH,
    S_PAIR_RD,
    S_PAIR_WR,
    S_RD_WAIT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_FIN,
    S_DONE
  } ctrl_state_t;

endpackage

// ----- sv/ubcs_if.sv -----
`timescale 1ns / 1ps

interface ubcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] token_word;
  logic [7:0]  byte_in;
  logic [6:0]  row_index;
  logic [6:0]  col_index;

  modport source (output valid, cmd, token_word, byte_in, row_index, col_index,
                  input ready);
  modport sink (input valid, cmd, token_word, byte_in, row_index, col_index,
                output ready);
endinterface

interface ubcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  result_index;
  logic        char_done;
  logic        pair_counted;
  logic [15:0] weight;

  modport source (output valid, status, result_index, char_done, pair_counted, weight,
                  input ready);
  modport sink (input valid, status, result_index, char_done, pair_counted, weight,
                output ready);
endinterface

// ----- sv/ubcs_ctrl.sv -----
`timescale 1ns / 1ps

module ubcs_ctrl
  import ubcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  ctrl_state_t state, state_next;
  logic        push;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      S_RST_CLEAR: begin
        op = OP_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (stat.cmd)
          CMD_START: begin
            op         = OP_CLR_INIT;
            state_next = S_CLEAR;
          end
          CMD_ADD: begin
            op         = OP_SRCH_INIT;
            state_next = S_SRCH;
          end
          CMD_BYTE: begin
            op         = OP_BYTE;
            state_next = stat.complete ? S_SRCH_INIT : S_DONE;
          end
          CMD_READ: begin
            op         = stat.rd_bad ? OP_RD_BAD : OP_RD_READ;
            state_next = stat.rd_bad ? S_DONE : S_RD_WAIT;
          end
          CMD_CLEAR: begin
            op         = OP_VOCAB_CLR;
            state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        op = OP_CLR_STEP;
        if (stat.clr_last) state_next = S_DONE;
      end
      S_SRCH_INIT: begin
        op         = OP_SRCH_INIT;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        op = OP_SRCH;
        if (stat.srch_hit) state_next = (stat.cmd == CMD_BYTE) ? S_PAIR_RD : S_DONE;
        else if (stat.srch_miss) state_next = S_DONE;
      end
      S_PAIR_RD: begin
        op         = OP_PAIR_RD;
        state_next = S_PAIR_WR;
      end
      S_PAIR_WR: begin
        op         = OP_PAIR_WR;
        state_next = S_DONE;
      end
      S_RD_WAIT: state_next = S_DIV_INIT;
      S_DIV_INIT: begin
        op         = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_DIV_FIN;
      end
      S_DIV_FIN: begin
        op         = OP_DIV_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          op         = OP_PUSH;
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ubcs_dp.sv -----
`timescale 1ns / 1ps

module ubcs_dp
  import ubcs_pkg::*;
#(
  parameter int VOCAB_ENTRIES    = 128,
  parameter int COUNT_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_op_t      op,
  output dp_stat_t    stat,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_token_word,
  input  logic [7:0]  in_byte,
  input  logic [6:0]  in_row,
  input  logic [6:0]  in_col,
  output logic [1:0]  status,
  output logic [6:0]  result_index,
  output logic        char_done,
  output logic        pair_counted,
  output logic [15:0] weight
);

  localparam int IW  = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
  localparam int SW  = $clog2(VOCAB_ENTRIES + 1);
  localparam int PD  = VOCAB_ENTRIES * VOCAB_ENTRIES;
  localparam int PW  = $clog2(PD);
  localparam int DW  = COUNT_BITS + 1;
  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int CW  = $clog2(F);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [F:0] WEIGHT_MAX = {1'b0, {F{1'b1}}};

  function automatic logic [31:0] cut_zero(input logic [31:0] w);
    logic [31:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (w[8*k +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*k +: 8] = w[8*k +: 8];
    end
    return r;
  endfunction

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] n;
    priority casez (b)
      8'b110?????: n = 2'd1;
      8'b1110????: n = 2'd2;
      8'b11110???: n = 2'd3;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

  // memories
  logic [31:0]           vocab_mem [VOCAB_ENTRIES];
  logic [COUNT_BITS-1:0] pair_mem  [PD];
  logic [COUNT_BITS-1:0] row_mem   [VOCAB_ENTRIES];
  logic [31:0]           vocab_rdata;
  logic [COUNT_BITS-1:0] pair_rdata, row_rdata;

  // latched request
  logic [2:0]  lat_cmd;
  logic [31:0] lat_token;
  logic [7:0]  lat_byte;
  logic [6:0]  lat_row, lat_col;

  // training state
  logic [SW-1:0] vocab_size;
  logic [31:0]   partial;
  logic [1:0]    bytes_left, byte_pos;
  logic [IW-1:0] prev_index;
  logic          prev_found, have_prev;
  logic [PW-1:0] clr_addr;

  // search
  logic [31:0]   key;
  logic [SW-1:0] srch_idx;
  logic [IW-1:0] pend_idx, found_idx;
  logic          pend;

  // divider
  logic [DW-1:0] div_den, div_r;
  logic [F:0]    div_q;
  logic [CW-1:0] div_cnt;

  // result being built
  logic [1:0]  res_status;
  logic [6:0]  res_idx;
  logic        res_done, res_counted;
  logic [15:0] res_weight;

  logic          hit, more, issue, complete;
  logic [31:0]   partial_n;
  logic [1:0]    bytes_left_n, byte_pos_n;
  logic          pair_ok;
  logic [PW-1:0] pair_addr;
  logic [IW-1:0] row_addr, row_ix, col_ix;
  logic          pair_we, row_we;
  logic [COUNT_BITS-1:0] pair_wdata, row_wdata;
  logic [DW-1:0] num_ext, den_ext;
  logic [DW:0]   r_shift;
  logic [F:0]    q_round;

  assign row_ix = IW'(lat_row);
  assign col_ix = IW'(lat_col);
  assign hit    = pend && (vocab_rdata == key);
  assign more   = srch_idx < vocab_size;
  assign issue  = !hit && more;

  // byte assembly
  always_comb begin
    partial_n    = partial;
    bytes_left_n = bytes_left;
    byte_pos_n   = byte_pos;
    complete     = 1'b0;
    if (bytes_left == 2'd0) begin
      partial_n = {24'd0, lat_byte};
      if (extra_bytes(lat_byte) == 2'd0) begin
        complete = 1'b1;
      end else begin
        bytes_left_n = extra_bytes(lat_byte);
        byte_pos_n   = 2'd1;
      end
    end else begin
      partial_n    = partial | ({24'd0, lat_byte} << {byte_pos, 3'd0});
      byte_pos_n   = byte_pos + 2'd1;
      bytes_left_n = bytes_left - 2'd1;
      complete     = (bytes_left == 2'd1);
    end
  end

  assign stat.cmd       = lat_cmd;
  assign stat.clr_last  = (clr_addr == PW'(PD - 1));
  assign stat.srch_hit  = hit;
  assign stat.srch_miss = !hit && !pend && !more;
  assign stat.complete  = complete;
  assign stat.rd_bad    = ({2'd0, lat_row} >= 9'(vocab_size))
                       || ({2'd0, lat_col} >= 9'(vocab_size));
  assign stat.div_last  = (div_cnt == CW'(F - 1));

  assign pair_ok = have_prev && prev_found && (row_rdata != COUNT_MAX);

  // memory address and write selection
  always_comb begin
    pair_we    = 1'b0;
    row_we     = 1'b0;
    pair_wdata = pair_rdata + COUNT_BITS'(1);
    row_wdata  = row_rdata + COUNT_BITS'(1);
    pair_addr  = PW'(row_ix) * PW'(VOCAB_ENTRIES) + PW'(col_ix);
    row_addr   = row_ix;
    unique case (op)
      OP_CLR_STEP: begin
        pair_addr  = clr_addr;
        row_addr   = IW'(clr_addr);
        pair_we    = 1'b1;
        row_we     = 1'b1;
        pair_wdata = '0;
        row_wdata  = '0;
      end
      OP_PAIR_RD: begin
        pair_addr = PW'(prev_index) * PW'(VOCAB_ENTRIES) + PW'(found_idx);
        row_addr  = prev_index;
      end
      OP_PAIR_WR: begin
        pair_addr = PW'(prev_index) * PW'(VOCAB_ENTRIES) + PW'(found_idx);
        row_addr  = prev_index;
        pair_we   = pair_ok;
        row_we    = pair_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_addr] <= pair_wdata;
    pair_rdata <= pair_mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_addr] <= row_wdata;
    row_rdata <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_SRCH && stat.srch_miss && lat_cmd == CMD_ADD
        && vocab_size < SW'(VOCAB_ENTRIES))
      vocab_mem[IW'(vocab_size)] <= key;
    vocab_rdata <= vocab_mem[IW'(srch_idx)];
  end

  // divider operands
  assign num_ext = DW'(pair_rdata) + DW'(1);
  assign den_ext = DW'(row_rdata) + DW'(vocab_size);
  assign r_shift = {div_r, 1'b0};
  assign q_round = div_q + ((r_shift >= {1'b0, div_den}) ? (F+1)'(1) : '0);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_size <= '0;
      partial    <= '0;
      bytes_left <= '0;
      byte_pos   <= '0;
      prev_index <= '0;
      prev_found <= 1'b0;
      have_prev  <= 1'b0;
      clr_addr   <= '0;
      pend       <= 1'b0;
      srch_idx   <= '0;
    end else begin
      unique case (op)
        OP_CLR_INIT: begin
          clr_addr   <= '0;
          partial    <= '0;
          bytes_left <= '0;
          byte_pos   <= '0;
          prev_index <= '0;
          prev_found <= 1'b0;
          have_prev  <= 1'b0;
        end
        OP_CLR_STEP: clr_addr <= clr_addr + PW'(1);
        OP_SRCH_INIT: begin
          pend     <= 1'b0;
          srch_idx <= '0;
        end
        OP_SRCH: begin
          pend     <= issue;
          pend_idx <= IW'(srch_idx);
          if (issue) srch_idx <= srch_idx + SW'(1);
          if (stat.srch_miss) begin
            if (lat_cmd == CMD_ADD && vocab_size < SW'(VOCAB_ENTRIES))
              vocab_size <= vocab_size + SW'(1);
            if (lat_cmd == CMD_BYTE) begin
              prev_index <= '0;
              prev_found <= 1'b0;
              have_prev  <= 1'b1;
            end
          end
        end
        OP_BYTE: begin
          bytes_left <= bytes_left_n;
          if (complete) begin
            partial  <= '0;
            byte_pos <= '0;
          end else begin
            partial  <= partial_n;
            byte_pos <= byte_pos_n;
          end
        end
        OP_PAIR_WR: begin
          prev_index <= found_idx;
          prev_found <= 1'b1;
          have_prev  <= 1'b1;
        end
        OP_VOCAB_CLR: begin
          vocab_size <= '0;
          prev_found <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LATCH: begin
        lat_cmd     <= in_cmd;
        lat_token   <= in_token_word;
        lat_byte    <= in_byte;
        lat_row     <= in_row;
        lat_col     <= in_col;
        res_status  <= ST_OK;
        res_idx     <= '0;
        res_done    <= 1'b0;
        res_counted <= 1'b0;
        res_weight  <= '0;
      end
      OP_SRCH_INIT: begin
        if (lat_cmd == CMD_ADD) key <= cut_zero(lat_token);
      end
      OP_BYTE: begin
        if (complete) key <= cut_zero(partial_n);
      end
      OP_SRCH: begin
        if (hit) begin
          found_idx <= pend_idx;
          res_idx   <= 7'(pend_idx);
          res_done  <= (lat_cmd == CMD_BYTE);
        end else if (stat.srch_miss && lat_cmd == CMD_ADD) begin
          if (vocab_size < SW'(VOCAB_ENTRIES)) res_idx <= 7'(vocab_size);
          else res_status <= ST_FULL;
        end
      end
      OP_PAIR_WR: res_counted <= pair_ok;
      OP_RD_BAD:  res_status <= ST_RANGE;
      OP_DIV_INIT: begin
        div_den <= den_ext;
        div_cnt <= '0;
        if (num_ext >= den_ext) begin
          div_q <= (F+1)'(1);
          div_r <= num_ext - den_ext;
        end else begin
          div_q <= '0;
          div_r <= num_ext;
        end
      end
      OP_DIV_STEP: begin
        div_cnt <= div_cnt + CW'(1);
        if (r_shift >= {1'b0, div_den}) begin
          div_r <= DW'(r_shift - {1'b0, div_den});
          div_q <= {div_q[F-1:0], 1'b1};
        end else begin
          div_r <= DW'(r_shift);
          div_q <= {div_q[F-1:0], 1'b0};
        end
      end
      OP_DIV_FIN: res_weight <= 16'((q_round > WEIGHT_MAX) ? WEIGHT_MAX : q_round);
      OP_PUSH: begin
        status       <= res_status;
        result_index <= res_idx;
        char_done    <= res_done;
        pair_counted <= res_counted;
        weight       <= res_weight;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/utf8_bigram_count_smoother_core.sv -----
`timescale 1ns / 1ps

// character bigram counter with add-one smoothed weight read-out
// req channel (valid/ready): one command per request; cmd selects start training,
//   add vocabulary token, corpus byte, read weight or clear vocabulary
// rsp channel (valid/ready): exactly one response per request, in request order
// commands run one at a time; a request is taken only in the idle state
// steps: clear vocabulary and unknown codes go straight to the output register;
//   a corpus byte that leaves a character open does likewise; add and a completed
//   character run a linear vocabulary search, and a completed character found
//   there then does a count read-modify-write; an in-range read weight runs
//   the bit-serial divider; start training sweeps the count memory
// reset: a clearing pass over the count memory zeroes pair counts and row
//   totals; req.ready stays low until it ends; vocabulary becomes empty
// stall: the response sits in an output register; the next request may be taken
//   while it waits, and that request holds in its final state until rsp drains
module utf8_bigram_count_smoother_core
  import ubcs_pkg::*;
#(
  parameter int VOCAB_ENTRIES    = 128,
  parameter int COUNT_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ubcs_in_if.sink   req,
  ubcs_out_if.source rsp
);

  dp_op_t   op;
  dp_stat_t stat;

  // sequencing of each command
  ubcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  // vocabulary, count memories, divider and output register
  ubcs_dp #(
    .VOCAB_ENTRIES    (VOCAB_ENTRIES),
    .COUNT_BITS       (COUNT_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .in_cmd        (req.cmd),
    .in_token_word (req.token_word),
    .in_byte       (req.byte_in),
    .in_row        (req.row_index),
    .in_col        (req.col_index),
    .status        (rsp.status),
    .result_index  (rsp.result_index),
    .char_done     (rsp.char_done),
    .pair_counted  (rsp.pair_counted),
    .weight        (rsp.weight)
  );

endmodule

// ----- sv/ubcs_checker.sv -----
`timescale 1ns / 1ps

module ubcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic        rsp_char_done,
  input logic        rsp_pair_counted,
  input logic [15:0] rsp_weight
);

  // clearing pass holds off requests right after reset
  a_reset_busy: assert property (@(posedge clk) $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("back to back request accepted");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight) && $stable(rsp_status))
    else $error("stalled response changed");

  a_weight_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_weight != 16'd0 |-> rsp_status == 2'd0 && !rsp_char_done)
    else $error("weight on a non-read response");

  a_counted_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_pair_counted |-> rsp_char_done)
    else $error("pair counted without a completed character");

endmodule

bind utf8_bigram_count_smoother_core ubcs_checker u_ubcs_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_char_done    (rsp.char_done),
  .rsp_pair_counted (rsp.pair_counted),
  .rsp_weight       (rsp.weight)
);
